// ===== sv/ctcp_pkg.sv =====
// Shared types and constants for the console text cell packer.
package ctcp_pkg;

   // Console geometry
   localparam int LINE_WIDTH   = 80;
   localparam int MSG_LINE_MAX = 25;

   // Kept line store: four cells per row
   localparam int KEPT_ROWS  = (LINE_WIDTH + 3) / 4;
   localparam int KEPT_ROW_W = $clog2(KEPT_ROWS);

   localparam logic [7:0] LINE_LIMIT   = 8'(LINE_WIDTH);
   localparam logic [5:0] LINE_BUDGET  = 6'(MSG_LINE_MAX);
   localparam logic [7:0] TAB_STOP     = 8'd8;
   localparam logic [7:0] ATTR_DEFAULT = 8'h0F;

   // Control characters
   localparam logic [7:0] CHAR_BS  = 8'd8;
   localparam logic [7:0] CHAR_TAB = 8'd9;
   localparam logic [7:0] CHAR_LF  = 8'd10;
   localparam logic [7:0] CHAR_CR  = 8'd13;

   typedef enum logic [1:0] {
      KIND_START_APPEND  = 2'd0,
      KIND_START_REPLACE = 2'd1,
      KIND_CELL_GROUP    = 2'd2,
      KIND_MESSAGE_END   = 2'd3
   } ctcp_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_PFX_READ,
      ST_PFX_EMIT,
      ST_CHAR,
      ST_END
   } ctcp_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic latch;
      logic emit_start;
      logic pfx_read;
      logic emit_group;
      logic do_char;
      logic emit_end;
   } ctcp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic slot_free;
      logic in_action;
      logic open;
      logic cursor_nonzero;
      logic end_due;
      logic pfx_last;
   } ctcp_sts_type;

endpackage

// ===== sv/ctcp_ctrl.sv =====
// Controller state machine for the console text cell packer.
module ctcp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ctcp_pkg::ctcp_sts_type sts,
   output ctcp_pkg::ctcp_cmd_type cmd
);
   import ctcp_pkg::*;

   ctcp_state_type state_ff;
   ctcp_state_type state_in;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (sts.in_action) begin
                  state_in = sts.open ? ST_END : ST_IDLE;
               end else begin
                  state_in = sts.open ? ST_CHAR : ST_START;
               end
            end
         end
         ST_START: begin
            if (sts.slot_free) begin
               state_in = sts.cursor_nonzero ? ST_PFX_READ : ST_CHAR;
            end
         end
         ST_PFX_READ: begin
            state_in = ST_PFX_EMIT;
         end
         ST_PFX_EMIT: begin
            if (sts.slot_free) begin
               state_in = sts.pfx_last ? ST_CHAR : ST_PFX_READ;
            end
         end
         ST_CHAR: begin
            if (sts.slot_free) begin
               state_in = sts.end_due ? ST_END : ST_IDLE;
            end
         end
         ST_END: begin
            if (sts.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         ST_START: begin
            cmd.emit_start = sts.slot_free;
         end
         ST_PFX_READ: begin
            cmd.pfx_read = 1'b1;
         end
         ST_PFX_EMIT: begin
            cmd.emit_group = sts.slot_free;
         end
         ST_CHAR: begin
            cmd.do_char = sts.slot_free;
         end
         ST_END: begin
            cmd.emit_end = sts.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/ctcp_datapath.sv =====
// Datapath: cursor, message state, kept line store and result register.
module ctcp_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ctcp_pkg::ctcp_cmd_type cmd,
   output ctcp_pkg::ctcp_sts_type sts,
   input  logic                   req_action,
   input  logic [7:0]             req_char_code,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_kind,
   output logic [4:0]             rsp_line_index,
   output logic [6:0]             rsp_column,
   output logic [2:0]             rsp_cell_count,
   output logic [63:0]            rsp_cells,
   output logic [4:0]             rsp_msg_lines,
   output logic                   rsp_last
);
   import ctcp_pkg::*;

   // Architectural state
   logic [7:0] attr_ff;
   logic [7:0] char_ff;
   logic [6:0] cursor_ff;
   logic [4:0] mline_ff;
   logic       open_ff;
   logic       replace_ff;
   logic [6:0] grp_col_ff;

   // Kept line store and its per-cell valid bits
   logic [3:0][15:0] kept_mem [KEPT_ROWS];
   logic [3:0][15:0] rd_cells_ff;
   logic [KEPT_ROWS-1:0][3:0] kept_valid_ff;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [4:0]  rsp_line_index_ff, rsp_line_index_in;
   logic [6:0]  rsp_column_ff, rsp_column_in;
   logic [2:0]  rsp_cell_count_ff, rsp_cell_count_in;
   logic [63:0] rsp_cells_ff, rsp_cells_in;
   logic [4:0]  rsp_msg_lines_ff, rsp_msg_lines_in;
   logic        rsp_last_ff, rsp_last_in;

   // Combinational terms
   logic                  slot_free;
   logic                  printable;
   logic [7:0]            cur_ext;
   logic [7:0]            cur_inc;
   logic [7:0]            tab_next;
   logic                  tab_wrap;
   logic                  new_line;
   logic [6:0]            cursor_next;
   logic [4:0]            eff_mline;
   logic                  eff_replace;
   logic [4:0]            mline_next;
   logic [4:0]            max_lines;
   logic                  end_due;
   logic [15:0]           glyph;
   logic [KEPT_ROW_W-1:0] cur_row;
   logic [1:0]            cur_lane;
   logic [KEPT_ROW_W-1:0] grp_row;
   logic [6:0]            grp_diff;
   logic [2:0]            grp_cnt;
   logic                  pfx_last;
   logic [63:0]           grp_cells;
   logic [5:0]            lc_raw;
   logic [4:0]            end_lc;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Decode the held character
   always_comb begin
      printable = !((char_ff == CHAR_BS) || (char_ff == CHAR_TAB) ||
                    (char_ff == CHAR_LF) || (char_ff == CHAR_CR));
      cur_ext   = {1'b0, cursor_ff};
      cur_inc   = cur_ext + 8'd1;
      tab_next  = (cur_ext + TAB_STOP) & ~(TAB_STOP - 8'd1);
      tab_wrap  = (char_ff == CHAR_TAB) && (tab_next >= LINE_LIMIT);
      new_line  = (char_ff == CHAR_LF) || tab_wrap || (printable && (cur_inc >= LINE_LIMIT));
      case (char_ff)
         CHAR_BS: begin
            cursor_next = (cursor_ff != 7'd0) ? cursor_ff - 7'd1 : 7'd0;
         end
         CHAR_TAB: begin
            cursor_next = tab_wrap ? 7'd0 : tab_next[6:0];
         end
         CHAR_LF, CHAR_CR: begin
            cursor_next = 7'd0;
         end
         default: begin
            cursor_next = (cur_inc >= LINE_LIMIT) ? 7'd0 : cur_inc[6:0];
         end
      endcase
   end

   // Line budget, as seen once the message is open
   always_comb begin
      eff_mline   = open_ff ? mline_ff : 5'd0;
      eff_replace = open_ff ? replace_ff : (cursor_ff != 7'd0);
      mline_next  = new_line ? eff_mline + 5'd1 : eff_mline;
      max_lines   = eff_replace ? 5'd1 : LINE_BUDGET[4:0];
      end_due     = mline_next >= max_lines;
      lc_raw      = {1'b0, mline_ff} + 6'd1;
      if (replace_ff) begin
         end_lc = 5'd0;
      end else begin
         end_lc = (lc_raw > LINE_BUDGET) ? LINE_BUDGET[4:0] : lc_raw[4:0];
      end
   end

   assign glyph    = {attr_ff, char_ff};
   assign cur_row  = cursor_ff[KEPT_ROW_W+1:2];
   assign cur_lane = cursor_ff[1:0];

   // Shape one prefix group from the read row
   always_comb begin
      grp_row  = grp_col_ff[KEPT_ROW_W+1:2];
      grp_diff = cursor_ff - grp_col_ff;
      grp_cnt  = (grp_diff > 7'd4) ? 3'd4 : grp_diff[2:0];
      pfx_last = ({1'b0, grp_col_ff} + 8'd4) >= cur_ext;
      for (int k = 0; k < 4; k++) begin
         grp_cells[16*k +: 16] = (kept_valid_ff[grp_row][k] && (3'(k) < grp_cnt)) ?
                                 rd_cells_ff[k] : 16'd0;
      end
   end

   // Select the next result
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_kind_in       = rsp_kind_ff;
      rsp_line_index_in = rsp_line_index_ff;
      rsp_column_in     = rsp_column_ff;
      rsp_cell_count_in = rsp_cell_count_ff;
      rsp_cells_in      = rsp_cells_ff;
      rsp_msg_lines_in  = rsp_msg_lines_ff;
      rsp_last_in       = rsp_last_ff;
      if (cmd.emit_start || cmd.emit_group || (cmd.do_char && printable) || cmd.emit_end) begin
         rsp_valid_in      = 1'b1;
         rsp_line_index_in = 5'd0;
         rsp_column_in     = 7'd0;
         rsp_cell_count_in = 3'd0;
         rsp_cells_in      = 64'd0;
         rsp_msg_lines_in  = 5'd0;
         if (cmd.emit_start) begin
            rsp_kind_in = (cursor_ff != 7'd0) ? KIND_START_REPLACE : KIND_START_APPEND;
            rsp_last_in = (cursor_ff == 7'd0) && !printable && !end_due;
         end else if (cmd.emit_group) begin
            rsp_kind_in       = KIND_CELL_GROUP;
            rsp_column_in     = grp_col_ff;
            rsp_cell_count_in = grp_cnt;
            rsp_cells_in      = grp_cells;
            rsp_last_in       = pfx_last && !printable && !end_due;
         end else if (cmd.do_char) begin
            rsp_kind_in       = KIND_CELL_GROUP;
            rsp_line_index_in = mline_ff;
            rsp_column_in     = cursor_ff;
            rsp_cell_count_in = 3'd1;
            rsp_cells_in      = {48'd0, glyph};
            rsp_last_in       = !end_due;
         end else begin
            rsp_kind_in       = KIND_MESSAGE_END;
            rsp_msg_lines_in  = end_lc;
            rsp_last_in       = 1'b1;
         end
      end
   end

   // Update control state
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff       <= ATTR_DEFAULT;
         cursor_ff     <= 7'd0;
         mline_ff      <= 5'd0;
         open_ff       <= 1'b0;
         replace_ff    <= 1'b0;
         kept_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         if (cmd.emit_start) begin
            open_ff    <= 1'b1;
            replace_ff <= (cursor_ff != 7'd0);
            mline_ff   <= 5'd0;
         end
         if (cmd.do_char) begin
            cursor_ff <= cursor_next;
            mline_ff  <= mline_next;
            if (new_line) begin
               kept_valid_ff <= '0;
            end else if (printable) begin
               kept_valid_ff[cur_row][cur_lane] <= 1'b1;
            end
         end
         if (cmd.emit_end) begin
            open_ff <= 1'b0;
         end
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         char_ff <= req_char_code;
      end
      if (cmd.emit_start) begin
         grp_col_ff <= 7'd0;
      end else if (cmd.emit_group) begin
         grp_col_ff <= grp_col_ff + 7'd4;
      end
      rsp_kind_ff       <= rsp_kind_in;
      rsp_line_index_ff <= rsp_line_index_in;
      rsp_column_ff     <= rsp_column_in;
      rsp_cell_count_ff <= rsp_cell_count_in;
      rsp_cells_ff      <= rsp_cells_in;
      rsp_msg_lines_ff  <= rsp_msg_lines_in;
      rsp_last_ff       <= rsp_last_in;
   end

   // Kept line store: one cell written, one row read per cycle
   always_ff @(posedge clock) begin
      if (cmd.do_char && printable) begin
         kept_mem[cur_row][cur_lane] <= glyph;
      end
      if (cmd.pfx_read) begin
         rd_cells_ff <= kept_mem[grp_row];
      end
   end

   // Report status
   always_comb begin
      sts.slot_free      = slot_free;
      sts.in_action      = req_action;
      sts.open           = open_ff;
      sts.cursor_nonzero = (cursor_ff != 7'd0);
      sts.end_due        = end_due;
      sts.pfx_last       = pfx_last;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_line_index = rsp_line_index_ff;
   assign rsp_column     = rsp_column_ff;
   assign rsp_cell_count = rsp_cell_count_ff;
   assign rsp_cells      = rsp_cells_ff;
   assign rsp_msg_lines  = rsp_msg_lines_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== sv/console_text_cell_packer.sv =====
// A printable character in an open message is latched on accept; its cell group is loaded
// into the result register once the output slot is free. Opening adds a start result, each
//   kept-prefix group of a replace adds a row read and a result; an end adds an end result.
// Results wait in an output register, so the next character is taken while one is pending.
// Reset (synchronous): cursor, line and message state and all kept-cell valid bits clear;
//   the cell attribute returns to 0x0F.
module console_text_cell_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_char_code,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [4:0]  rsp_line_index,
   output logic [6:0]  rsp_column,
   output logic [2:0]  rsp_cell_count,
   output logic [63:0] rsp_cells,
   output logic [4:0]  rsp_msg_lines,
   output logic        rsp_last
);
   import ctcp_pkg::*;

   ctcp_cmd_type cmd;
   ctcp_sts_type sts;

   // Sequence each transfer
   ctcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Cursor, store and result register
   ctcp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_line_index (rsp_line_index),
      .rsp_column     (rsp_column),
      .rsp_cell_count (rsp_cell_count),
      .rsp_cells      (rsp_cells),
      .rsp_msg_lines  (rsp_msg_lines),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the console text cell packer: print stream in, cell messages out.
`timescale 1ns / 100ps

module tb_top;
   import ctcp_pkg::*;

   localparam logic ACT_CHAR    = 1'b0;
   localparam logic ACT_END     = 1'b1;
   localparam int   CYCLE_LIMIT = 600_000;
   localparam int   SETTLE      = 8;

   typedef struct packed {
      logic       action;
      logic [7:0] char_code;
   } print_item_type;

   typedef struct {
      logic [1:0]  kind;
      logic [4:0]  line_index;
      logic [6:0]  column;
      logic [2:0]  cell_count;
      logic [63:0] cells;
      logic [4:0]  msg_lines;
      logic        last;
   } console_result_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_action    = ACT_CHAR;
   logic [7:0]  req_char_code = '0;
   logic        csr_wr_en     = 1'b0;
   logic [7:0]  csr_wr_data   = '0;
   logic        rsp_stall     = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [4:0]  rsp_line_index;
   logic [6:0]  rsp_column;
   logic [2:0]  rsp_cell_count;
   logic [63:0] rsp_cells;
   logic [4:0]  rsp_msg_lines;
   logic        rsp_last;

   // Print characters waiting to go out, and console results still owed by the block
   print_item_type     print_stream[$];
   console_result_type packed_msgs[$];

   // Console state as the block should hold it
   logic [7:0]  cell_attr = ATTR_DEFAULT;
   int          cur_col   = 0;
   int          msg_line  = 0;
   bit          msg_open  = 1'b0;
   bit          msg_replace = 1'b0;
   logic [15:0] kept_cells [LINE_WIDTH] = '{default: '0};

   // Idling knobs, set per phase
   bit sender_gaps = 1'b0;
   int stall_pct   = 0;

   int mismatch_count   = 0;
   int items_sent       = 0;
   int print_ends_sent  = 0;
   int results_checked  = 0;
   int groups_checked   = 0;
   int msg_ends_checked = 0;
   int full_msgs        = 0;
   int cycles_run       = 0;

   console_text_cell_packer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_line_index (rsp_line_index),
      .rsp_column     (rsp_column),
      .rsp_cell_count (rsp_cell_count),
      .rsp_cells      (rsp_cells),
      .rsp_msg_lines  (rsp_msg_lines),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic console_result_type make_result(input logic [1:0] kind, input int line,
                                                      input int col, input int count,
                                                      input logic [63:0] cells, input int lc);
      console_result_type r;
      r.kind       = kind;
      r.line_index = 5'(line);
      r.column     = 7'(col);
      r.cell_count = 3'(count);
      r.cells      = cells;
      r.msg_lines  = 5'(lc);
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic void start_new_line();
      cur_col    = 0;
      msg_line   = (msg_line + 1) & 31;
      kept_cells = '{default: '0};
   endfunction

   function automatic console_result_type close_message();
      int lc;
      lc = 0;
      if (!msg_replace) begin
         lc = (msg_line + 1 > MSG_LINE_MAX) ? MSG_LINE_MAX : msg_line + 1;
      end
      msg_open = 1'b0;
      return make_result(KIND_MESSAGE_END, 0, 0, 0, '0, lc);
   endfunction

   // Advance the console state by one print item and queue the results it owes
   task automatic pack_console_cells(input logic action, input logic [7:0] ch);
      console_result_type batch[$];
      logic [63:0]     prefix;
      logic [15:0]     glyph_cell;
      int              cnt;
      int              tab_col;
      int              line_budget;
      if (action == ACT_END) begin
         if (msg_open) batch.push_back(close_message());
      end else begin
         if (!msg_open) begin
            msg_open    = 1'b1;
            msg_replace = (cur_col != 0);
            msg_line    = 0;
            batch.push_back(make_result(msg_replace ? KIND_START_REPLACE : KIND_START_APPEND,
                                        0, 0, 0, '0, 0));
            // copy the kept prefix of the last line, four cells per group
            if (msg_replace) begin
               for (int i = 0; i < cur_col; i += 4) begin
                  cnt    = (cur_col - i > 4) ? 4 : cur_col - i;
                  prefix = '0;
                  for (int k = 0; k < cnt; k++) prefix[16*k +: 16] = kept_cells[i + k];
                  batch.push_back(make_result(KIND_CELL_GROUP, 0, i, cnt, prefix, 0));
               end
            end
         end
         case (ch)
            CHAR_BS: begin
               if (cur_col != 0) cur_col--;
            end
            CHAR_TAB: begin
               tab_col = (cur_col + int'(TAB_STOP)) & ~(int'(TAB_STOP) - 1);
               if (tab_col >= LINE_WIDTH) start_new_line();
               else cur_col = tab_col;
            end
            CHAR_LF: start_new_line();
            CHAR_CR: cur_col = 0;
            default: begin
               glyph_cell = {cell_attr, ch};
               batch.push_back(make_result(KIND_CELL_GROUP, msg_line, cur_col, 1,
                                           64'(glyph_cell), 0));
               kept_cells[cur_col] = glyph_cell;
               cur_col++;
               if (cur_col >= LINE_WIDTH) start_new_line();
            end
         endcase
         line_budget = msg_replace ? 1 : MSG_LINE_MAX;
         if (msg_line >= line_budget) batch.push_back(close_message());
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) packed_msgs.push_back(batch[i]);
   endtask

   // Drive print items: bursts of random length with random gaps in between when sender_gaps is set
   always @(posedge clock) begin : print_driver
      print_item_type upcoming;
      int          burst_left;
      int          gap_left;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pack_console_cells(req_action, req_char_code);
            items_sent++;
            if (req_action == ACT_END) print_ends_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (print_stream.size() > 0) begin
               upcoming = print_stream.pop_front();
               req_valid     <= 1'b1;
               req_action    <= upcoming.action;
               req_char_code <= upcoming.char_code;
               if (sender_gaps) begin
                  if (burst_left > 0) burst_left--;
                  else begin
                     burst_left = $urandom_range(0, 15);
                     gap_left   = $urandom_range(1, 12);
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Check each result transfer against the oldest owed result; stall in random runs
   always @(posedge clock) begin : result_monitor
      console_result_type want;
      int              stall_run;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (packed_msgs.size() == 0) begin
               $error("unexpected result: kind %0d with nothing owed", rsp_kind);
               mismatch_count++;
            end else begin
               want = packed_msgs.pop_front();
               check_field("kind",       64'(want.kind),       64'(rsp_kind));
               check_field("line_index", 64'(want.line_index), 64'(rsp_line_index));
               check_field("column",     64'(want.column),     64'(rsp_column));
               check_field("cell_count", 64'(want.cell_count), 64'(rsp_cell_count));
               check_field("cells",      want.cells,           rsp_cells);
               check_field("line_count", 64'(want.msg_lines),  64'(rsp_msg_lines));
               check_field("last",       64'(want.last),       64'(rsp_last));
               results_checked++;
               if (want.kind == KIND_CELL_GROUP) groups_checked++;
               if (want.kind == KIND_MESSAGE_END) msg_ends_checked++;
               if (want.kind == KIND_MESSAGE_END && want.msg_lines == MSG_LINE_MAX)
                  full_msgs++;
            end
         end
         if (stall_run > 0) stall_run--;
         else begin
            stall_run = $urandom_range(0, 10);
            rsp_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void push_print(input logic action, input logic [7:0] ch);
      print_item_type it;
      it.action    = action;
      it.char_code = ch;
      print_stream.push_back(it);
   endfunction

   function automatic logic [7:0] pick_text_char();
      logic [7:0] ctrl [4] = '{CHAR_BS, CHAR_TAB, CHAR_LF, CHAR_CR};
      if ($urandom_range(0, 15) == 0) return ctrl[$urandom_range(0, 3)];
      return 8'($urandom_range(32, 126));
   endfunction

   // Queue print calls of mixed shape: short text, long lines, many lines, tabs, noise
   task automatic queue_print_calls(input int budget);
      int start_size;
      int n;
      start_size = print_stream.size();
      while (print_stream.size() - start_size < budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               n = $urandom_range(1, 12);
               repeat (n) push_print(ACT_CHAR, pick_text_char());
            end
            3: begin
               n = $urandom_range(60, 170);
               repeat (n) push_print(ACT_CHAR, 8'($urandom_range(32, 126)));
            end
            4: begin
               n = $urandom_range(24, 34);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0) push_print(ACT_CHAR, pick_text_char());
                  push_print(ACT_CHAR, CHAR_LF);
               end
            end
            5: begin
               n = $urandom_range(1, 12);
               repeat (n) begin
                  if ($urandom_range(0, 1) == 0) push_print(ACT_CHAR, CHAR_TAB);
                  else push_print(ACT_CHAR, 8'($urandom_range(32, 126)));
               end
            end
            6: begin
               n = $urandom_range(2, 10);
               repeat (n) begin
                  case ($urandom_range(0, 3))
                     0: push_print(ACT_CHAR, CHAR_BS);
                     1: push_print(ACT_CHAR, CHAR_CR);
                     2: push_print(ACT_CHAR, CHAR_TAB);
                     default: push_print(ACT_CHAR, 8'($urandom_range(32, 126)));
                  endcase
               end
            end
            7, 8: begin
               n = $urandom_range(1, 8);
               repeat (n) push_print($urandom_range(0, 1) ? ACT_END : ACT_CHAR,
                                     8'($urandom_range(0, 255)));
            end
            default: begin
               n = $urandom_range(1, 10);
               repeat (n) push_print(ACT_CHAR, 8'($urandom_range(0, 255)));
            end
         endcase
         // close the print call most of the time
         if ($urandom_range(0, 4) != 0) push_print(ACT_END, 8'($urandom_range(0, 255)));
      end
      // drop the overshoot so the phase sends its budget
      while (print_stream.size() - start_size > budget) void'(print_stream.pop_back());
   endtask

   // Hold until the sender is idle and every owed result has come, then let the block settle
   task automatic wait_for_drain();
      do @(negedge clock);
      while (print_stream.size() > 0 || req_valid || packed_msgs.size() > 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic run_phase(input logic [7:0] attr, input bit gaps, input int stall_level,
                            input int budget);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= attr;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cell_attr = attr;
      @(negedge clock);
      sender_gaps = gaps;
      stall_pct   = stall_level;
      queue_print_calls(budget / 2);
      wait_for_drain();
      queue_print_calls(budget - budget / 2);
      wait_for_drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: append open, byte extremes, backspace, end with nothing open,
      // replace with prefix copy, backspace at column zero, newline ending a replace,
      // tab run that wraps the line
      sender_gaps = 1'b1;
      stall_pct   = 30;
      push_print(ACT_CHAR, "A");
      push_print(ACT_CHAR, 8'h00);
      push_print(ACT_CHAR, 8'hFF);
      push_print(ACT_CHAR, CHAR_BS);
      push_print(ACT_CHAR, "B");
      push_print(ACT_END, 8'h00);
      push_print(ACT_END, 8'hFF);
      push_print(ACT_CHAR, "C");
      push_print(ACT_CHAR, CHAR_BS);
      push_print(ACT_CHAR, CHAR_CR);
      push_print(ACT_CHAR, CHAR_BS);
      push_print(ACT_CHAR, CHAR_LF);
      repeat (10) push_print(ACT_CHAR, CHAR_TAB);
      push_print(ACT_END, 8'h00);
      push_print(ACT_CHAR, 8'h80);
      push_print(ACT_END, 8'h7F);
      wait_for_drain();

      // Random phases across attribute settings and idling mixes
      run_phase(8'hFF, 1'b0, 0, 96);
      run_phase(8'h00, 1'b1, 30, 96);
      run_phase(8'($urandom_range(0, 255)), 1'b1, 60, 96);
      run_phase(8'h5A, 1'b0, 45, 96);
      run_phase(8'($urandom_range(0, 255)), 1'b1, 0, 96);

      $display("Sent %0d print items (%0d end-of-print) over six attribute settings.",
               items_sent, print_ends_sent);
      $display("Checked %0d results: %0d cell groups, %0d message ends, %0d full messages.",
               results_checked, groups_checked, msg_ends_checked, full_msgs);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
